/* rtl/sprite_alpha_blit_clip_top_assert.svh */
// Assertion macros used by the sprite blitter checker.
`ifndef SPRITE_ALPHA_BLIT_CLIP_TOP_ASSERT_SVH
`define SPRITE_ALPHA_BLIT_CLIP_TOP_ASSERT_SVH

// Implication checked in the same cycle.
`define SABC_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Implication checked in the next cycle.
`define SABC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/sabc_pkg.sv */
// Package with types and constants of the sprite alpha blitter.
`timescale 1ns / 1ps

package sabc_pkg;

    localparam int CH_W       = 8;
    localparam int ADDR_W     = 22;
    localparam int SCR_REG_W  = 12;
    localparam int SPR_REG_W  = 11;
    localparam int POS_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int BLEND_SHIFT = 8;
    localparam logic [CH_W-1:0] ALPHA_FULL = 8'd255;
    localparam logic [CH_W-1:0] ALPHA_NONE = 8'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_X         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OPAQUE_MODE   = 3'd6;

    localparam logic [SCR_REG_W-1:0] RST_SCREEN_WIDTH  = 12'd1024;
    localparam logic [SCR_REG_W-1:0] RST_SCREEN_HEIGHT = 12'd768;
    localparam logic [SPR_REG_W-1:0] RST_SPRITE_WIDTH  = 11'd64;
    localparam logic [SPR_REG_W-1:0] RST_SPRITE_HEIGHT = 11'd64;

    typedef struct packed {
        logic            first_pixel;
        logic [CH_W-1:0] src_red;
        logic [CH_W-1:0] src_green;
        logic [CH_W-1:0] src_blue;
        logic [CH_W-1:0] src_alpha;
        logic [CH_W-1:0] dst_red;
        logic [CH_W-1:0] dst_green;
        logic [CH_W-1:0] dst_blue;
        logic [CH_W-1:0] dst_alpha;
    } pixel_t;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] dest_address;
        logic [CH_W-1:0]   out_red;
        logic [CH_W-1:0]   out_green;
        logic [CH_W-1:0]   out_blue;
        logic [CH_W-1:0]   out_alpha;
        logic              last_pixel;
    } result_t;

endpackage

/* rtl/sprite_alpha_blit_clip_top.sv */
// Streaming sprite blitter with alpha blending and per-pixel screen clipping.
//
// Usage:
//   pixel channel  : one sprite pixel per request, in raster order, with the
//                    destination pixel beneath it; first_pixel restarts the
//                    row and column counters at the top-left corner.
//   result channel : one result per pixel: write enable, framebuffer address
//                    and the four output bytes, plus the last-pixel mark.
//   cfg channel    : register writes by index, always ready; write only while
//                    no pixel is in flight.
// Three register stages lie between pixel request and result valid: placement
// and counters, then the address multiply and blend products, then the final
// add and select. Throughput is one pixel per clock while the receiver takes
// results; each of the three register stages holds one request and moves on
// whenever the stage after it frees up.
// When the receiver stalls, the result register holds and the stages behind
// it fill; pixel_ready drops once all three stages are full.
// Reset empties the pipeline, zeroes the counters and loads the register
// defaults: 1024 x 768 screen, 64 x 64 sprite at 0,0, blend mode.
`timescale 1ns / 1ps

module sprite_alpha_blit_clip_top
    import sabc_pkg::*;
#(
    parameter int MAX_SCREEN_DIM = 2048,
    parameter int MAX_SPRITE_DIM = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  pixel_t                pixel,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SCR_DIM_W  = $clog2(MAX_SCREEN_DIM + 1);
    localparam int SPR_DIM_W  = $clog2(MAX_SPRITE_DIM + 1);
    localparam int CNT_W      = $clog2(MAX_SPRITE_DIM);
    localparam int POS_EXT_W  = (POS_W > CNT_W + 1) ? POS_W : CNT_W + 1;
    localparam int SX_W       = POS_EXT_W + 1;
    localparam int PROD_W     = 2 * SCR_DIM_W;
    localparam int ADDR_SUM_W = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W;
    localparam int BPROD_W    = 2 * CH_W + 2;

    // configuration registers
    logic [SCR_REG_W-1:0]    screen_width_reg;
    logic [SCR_REG_W-1:0]    screen_height_reg;
    logic [SPR_REG_W-1:0]    sprite_width_reg;
    logic [SPR_REG_W-1:0]    sprite_height_reg;
    logic signed [POS_W-1:0] pos_x_reg;
    logic signed [POS_W-1:0] pos_y_reg;
    logic                    opaque_mode_reg;

    // clamped sizes
    logic [SCR_DIM_W-1:0] sw;
    logic [SCR_DIM_W-1:0] sh;
    logic [SPR_DIM_W-1:0] spw;
    logic [SPR_DIM_W-1:0] sph;

    // raster counters
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] row_next;
    logic [CNT_W-1:0] col_use;
    logic [CNT_W-1:0] row_use;
    logic [CNT_W:0]   col_inc;
    logic [CNT_W:0]   row_inc;

    logic signed [SX_W-1:0] sx;
    logic signed [SX_W-1:0] sy;
    logic                   visible;
    logic                   last;

    // handshake
    logic pixel_acc;
    logic s1_ready;
    logic s2_ready;
    logic out_ready;

    // stage 1
    logic                 s1_valid_reg;
    pixel_t               s1_pix_reg;
    logic [SCR_DIM_W-1:0] s1_sx_reg;
    logic [SCR_DIM_W-1:0] s1_sy_reg;
    logic                 s1_visible_reg;
    logic                 s1_last_reg;

    // stage 2
    logic                     s2_valid_reg;
    pixel_t                   s2_pix_reg;
    logic [PROD_W-1:0]        s2_addr_prod_reg;
    logic [SCR_DIM_W-1:0]     s2_sx_reg;
    logic                     s2_visible_reg;
    logic                     s2_last_reg;
    logic                     s2_copy_reg;
    logic                     s2_blend_reg;
    logic [CH_W-1:0]          s2_q_red_reg;
    logic [CH_W-1:0]          s2_q_green_reg;
    logic [CH_W-1:0]          s2_q_blue_reg;
    logic signed [BPROD_W-1:0] prod_red;
    logic signed [BPROD_W-1:0] prod_green;
    logic signed [BPROD_W-1:0] prod_blue;
    logic signed [CH_W:0]      alpha_s;
    logic signed [CH_W:0]      diff_red;
    logic signed [CH_W:0]      diff_green;
    logic signed [CH_W:0]      diff_blue;

    // output stage
    logic                  result_valid_reg;
    result_t               result_reg;
    result_t               result_next;
    logic [ADDR_SUM_W-1:0] addr_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= RST_SCREEN_WIDTH;
            screen_height_reg <= RST_SCREEN_HEIGHT;
            sprite_width_reg  <= RST_SPRITE_WIDTH;
            sprite_height_reg <= RST_SPRITE_HEIGHT;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            opaque_mode_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[SCR_REG_W-1:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[SCR_REG_W-1:0];
                CFG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_data[SPR_REG_W-1:0];
                CFG_SPRITE_HEIGHT: sprite_height_reg <= cfg_data[SPR_REG_W-1:0];
                CFG_POS_X:         pos_x_reg         <= $signed(cfg_data[POS_W-1:0]);
                CFG_POS_Y:         pos_y_reg         <= $signed(cfg_data[POS_W-1:0]);
                CFG_OPAQUE_MODE:   opaque_mode_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (screen_width_reg == '0)
            sw = SCR_DIM_W'(1);
        else if (screen_width_reg > MAX_SCREEN_DIM)
            sw = SCR_DIM_W'(MAX_SCREEN_DIM);
        else
            sw = SCR_DIM_W'(screen_width_reg);

        if (screen_height_reg == '0)
            sh = SCR_DIM_W'(1);
        else if (screen_height_reg > MAX_SCREEN_DIM)
            sh = SCR_DIM_W'(MAX_SCREEN_DIM);
        else
            sh = SCR_DIM_W'(screen_height_reg);

        if (sprite_width_reg == '0)
            spw = SPR_DIM_W'(1);
        else if (sprite_width_reg > MAX_SPRITE_DIM)
            spw = SPR_DIM_W'(MAX_SPRITE_DIM);
        else
            spw = SPR_DIM_W'(sprite_width_reg);

        if (sprite_height_reg == '0)
            sph = SPR_DIM_W'(1);
        else if (sprite_height_reg > MAX_SPRITE_DIM)
            sph = SPR_DIM_W'(MAX_SPRITE_DIM);
        else
            sph = SPR_DIM_W'(sprite_height_reg);
    end

    assign out_ready   = !result_valid_reg || result_ready;
    assign s2_ready    = !s2_valid_reg || out_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign pixel_ready = s1_ready;
    assign pixel_acc   = pixel_valid && s1_ready;

    // placement and counter advance
    always_comb
    begin
        col_use = pixel.first_pixel ? '0 : col_reg;
        row_use = pixel.first_pixel ? '0 : row_reg;

        sx = $signed(SX_W'(pos_x_reg)) + $signed(SX_W'(col_use));
        sy = $signed(SX_W'(pos_y_reg)) + $signed(SX_W'(row_use));
        visible = !sx[SX_W-1] && !sy[SX_W-1]
                  && ($unsigned(sx) < sw) && ($unsigned(sy) < sh);
        last = (col_use == spw - 1'b1) && (row_use == sph - 1'b1);

        col_inc = {1'b0, col_use} + 1'b1;
        row_inc = {1'b0, row_use} + 1'b1;
        if (col_inc >= spw)
        begin
            col_next = '0;
            if (row_inc >= sph)
                row_next = '0;
            else
                row_next = CNT_W'(row_inc);
        end
        else
        begin
            col_next = CNT_W'(col_inc);
            if (row_use >= sph)
                row_next = '0;
            else
                row_next = row_use;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (pixel_acc)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s1_ready)
                s1_valid_reg <= pixel_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (out_ready)
                result_valid_reg <= s2_valid_reg;
        end
    end

    // blend products
    always_comb
    begin
        alpha_s    = $signed({1'b0, s1_pix_reg.src_alpha});
        diff_red   = $signed({1'b0, s1_pix_reg.src_red})   - $signed({1'b0, s1_pix_reg.dst_red});
        diff_green = $signed({1'b0, s1_pix_reg.src_green}) - $signed({1'b0, s1_pix_reg.dst_green});
        diff_blue  = $signed({1'b0, s1_pix_reg.src_blue})  - $signed({1'b0, s1_pix_reg.dst_blue});
        prod_red   = BPROD_W'(alpha_s) * BPROD_W'(diff_red);
        prod_green = BPROD_W'(alpha_s) * BPROD_W'(diff_green);
        prod_blue  = BPROD_W'(alpha_s) * BPROD_W'(diff_blue);
    end

    always_ff @(posedge clk)
    begin
        if (pixel_acc)
        begin
            s1_pix_reg     <= pixel;
            s1_sx_reg      <= SCR_DIM_W'(sx);
            s1_sy_reg      <= SCR_DIM_W'(sy);
            s1_visible_reg <= visible;
            s1_last_reg    <= last;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_pix_reg       <= s1_pix_reg;
            s2_addr_prod_reg <= PROD_W'(s1_sy_reg) * PROD_W'(sw);
            s2_sx_reg        <= s1_sx_reg;
            s2_visible_reg   <= s1_visible_reg;
            s2_last_reg      <= s1_last_reg;
            s2_copy_reg      <= opaque_mode_reg || (s1_pix_reg.src_alpha == ALPHA_FULL);
            s2_blend_reg     <= s1_pix_reg.src_alpha != ALPHA_NONE;
            // low byte of the arithmetic shift is all the 8-bit sum needs
            s2_q_red_reg     <= prod_red[BLEND_SHIFT+CH_W-1:BLEND_SHIFT];
            s2_q_green_reg   <= prod_green[BLEND_SHIFT+CH_W-1:BLEND_SHIFT];
            s2_q_blue_reg    <= prod_blue[BLEND_SHIFT+CH_W-1:BLEND_SHIFT];
        end
        if (s2_valid_reg && out_ready)
            result_reg <= result_next;
    end

    // final add and select
    always_comb
    begin
        addr_sum = ADDR_SUM_W'(s2_addr_prod_reg) + ADDR_SUM_W'(s2_sx_reg);

        result_next              = '0;
        result_next.last_pixel   = s2_last_reg;
        result_next.write_enable = s2_visible_reg && (s2_copy_reg || s2_blend_reg);
        if (s2_visible_reg)
            result_next.dest_address = addr_sum[ADDR_W-1:0];
        if (s2_visible_reg && s2_copy_reg)
        begin
            result_next.out_red   = s2_pix_reg.src_red;
            result_next.out_green = s2_pix_reg.src_green;
            result_next.out_blue  = s2_pix_reg.src_blue;
            result_next.out_alpha = s2_pix_reg.src_alpha;
        end
        else if (s2_visible_reg && s2_blend_reg)
        begin
            result_next.out_red   = s2_pix_reg.dst_red   + s2_q_red_reg;
            result_next.out_green = s2_pix_reg.dst_green + s2_q_green_reg;
            result_next.out_blue  = s2_pix_reg.dst_blue  + s2_q_blue_reg;
            result_next.out_alpha = s2_pix_reg.dst_alpha;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* rtl/sabc_checker.sv */
// Port-level checker for the sprite blitter and its bind to the top level.
`timescale 1ns / 1ps
`include "sprite_alpha_blit_clip_top_assert.svh"

module sabc_checker
    import sabc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    pixel_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result,
    input logic    cfg_valid,
    input logic    cfg_ready
);

    logic result_stall;
    logic no_write;
    logic color_zero;

    assign result_stall = result_valid && !result_ready;
    assign no_write     = result_valid && !result.write_enable;
    assign color_zero   = result.out_red == '0 && result.out_green == '0
                          && result.out_blue == '0 && result.out_alpha == '0;

    // stalled result holds
    `SABC_ASSERT_NEXT(a_result_hold, result_stall, result_valid && $stable(result), "result moved")

    // no write means all color bytes are zero
    `SABC_ASSERT_NOW(a_nowrite_zero, no_write, color_zero, "color bytes set without write")

    // an empty result register never back-pressures the pixel channel
    `SABC_ASSERT_NOW(a_empty_ready, !result_valid, pixel_ready, "pixel stalled with empty output")

    // configuration writes are never stalled
    `SABC_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config request stalled")

endmodule

bind sprite_alpha_blit_clip_top sabc_checker u_sabc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_ready  (pixel_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
